// ===== design/lpm_pkg.sv =====
// Shared types and constants for the longest-prefix-match route lookup.
package lpm_pkg;

  // Field widths
  localparam int IDX_W  = 10;
  localparam int ADDR_W = 32;
  localparam int PORT_W = 8;
  localparam int LAST_W = 11;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 56;

  // Operation codes carried in s_tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Configuration register indexes
  localparam logic CFG_FIRST_ENTRY = 1'b0;
  localparam logic CFG_LAST_ENTRY  = 1'b1;

  // One route table entry
  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gateway;
    logic [PORT_W-1:0] port;
  } route_entry_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } lpm_state_t;

  // Controller to datapath
  typedef struct packed {
    logic wr_en;
    logic start;
    logic issue;
    logic load_out;
  } lpm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic range_empty;
    logic at_end;
    logic out_free;
  } lpm_sts_t;

endpackage

// ===== design/lpm_ctrl.sv =====
// Sequencer for route writes and table scans.
module lpm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_op,
  input  lpm_pkg::lpm_sts_t sts,
  output logic             in_ready,
  output lpm_pkg::lpm_cmd_t cmd
);

  lpm_pkg::lpm_state_t state, state_next;
  logic accept;

  assign accept = in_valid && in_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lpm_pkg::ST_IDLE: begin
        if (accept && in_op == lpm_pkg::OP_LOOKUP) begin
          state_next = sts.range_empty ? lpm_pkg::ST_DONE : lpm_pkg::ST_SCAN;
        end
      end
      lpm_pkg::ST_SCAN: begin
        if (sts.at_end) begin
          state_next = lpm_pkg::ST_DRAIN;
        end
      end
      lpm_pkg::ST_DRAIN: state_next = lpm_pkg::ST_DONE;
      lpm_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_next = lpm_pkg::ST_IDLE;
        end
      end
      default: state_next = lpm_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready     = (state == lpm_pkg::ST_IDLE);
    cmd.wr_en    = accept && in_op == lpm_pkg::OP_WRITE;
    cmd.start    = accept && in_op == lpm_pkg::OP_LOOKUP;
    cmd.issue    = (state == lpm_pkg::ST_SCAN);
    cmd.load_out = (state == lpm_pkg::ST_DONE) && sts.out_free;
  end

endmodule

// ===== design/lpm_dp.sv =====
// Route table memory, scan cursor, best-match tracking and result register.
module lpm_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lpm_pkg::lpm_cmd_t             cmd,
  output lpm_pkg::lpm_sts_t             sts,
  // configuration
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [lpm_pkg::LAST_W-1:0]    cfg_data,
  // input fields
  input  logic [lpm_pkg::IDX_W-1:0]     entry_index,
  input  lpm_pkg::route_entry_t         wr_entry,
  input  logic [lpm_pkg::ADDR_W-1:0]    dest_addr,
  // result
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [lpm_pkg::IDX_W-1:0]     match_index,
  output logic [lpm_pkg::ADDR_W-1:0]    match_gateway,
  output logic [lpm_pkg::PORT_W-1:0]    match_port
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // wide enough for TABLE_DEPTH itself and any 10-bit index
  localparam int CW = ((IW > lpm_pkg::IDX_W) ? IW : lpm_pkg::IDX_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] TOP_C   = CW'(TABLE_DEPTH - 1);

  lpm_pkg::route_entry_t mem [TABLE_DEPTH];

  logic [lpm_pkg::IDX_W-1:0]  first_entry;
  logic [lpm_pkg::LAST_W-1:0] last_entry;

  logic [IW-1:0]              cursor;
  logic [IW-1:0]              hi;
  logic [lpm_pkg::ADDR_W-1:0] dest;

  lpm_pkg::route_entry_t      rd_data;
  logic [IW-1:0]              rd_index;
  logic                       rd_vld;

  logic                       hit;
  logic [IW-1:0]              best_index;
  lpm_pkg::route_entry_t      best;

  logic [CW-1:0] first_ext, last_ext, wr_ext, hi_ext;
  logic          wr_in_range, matched, better;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_entry <= '0;
      last_entry  <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpm_pkg::CFG_FIRST_ENTRY: first_entry <= cfg_data[lpm_pkg::IDX_W-1:0];
        lpm_pkg::CFG_LAST_ENTRY:  last_entry  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Range bounds: last is clipped to the table top, negative last is empty
  always_comb begin
    first_ext = CW'(first_entry);
    last_ext  = CW'(last_entry[lpm_pkg::IDX_W-1:0]);
    hi_ext    = (last_ext >= DEPTH_C) ? TOP_C : last_ext;
    sts.range_empty = last_entry[lpm_pkg::LAST_W-1] || (first_ext > last_ext) ||
                      (first_ext >= DEPTH_C);
    sts.at_end      = (cursor == hi);
    sts.out_free    = !out_valid || out_ready;
  end

  assign wr_ext      = CW'(entry_index);
  assign wr_in_range = wr_ext < DEPTH_C;

  // Table memory: writes while idle, one read per scan cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_in_range) begin
      mem[wr_ext[IW-1:0]] <= wr_entry;
    end
    if (cmd.issue) begin
      rd_data <= mem[cursor];
    end
  end

  // Scan cursor and read tag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.issue;
    end
    if (cmd.start) begin
      cursor <= first_ext[IW-1:0];
      hi     <= hi_ext[IW-1:0];
      dest   <= dest_addr;
    end else if (cmd.issue) begin
      cursor <= cursor + 1'b1;
    end
    if (cmd.issue) begin
      rd_index <= cursor;
    end
  end

  // Match test; strictly larger mask wins so the lower slot keeps ties
  assign matched = (dest & rd_data.mask) == rd_data.prefix;
  assign better  = !hit || (rd_data.mask > best.mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (cmd.start) begin
      hit <= 1'b0;
    end else if (rd_vld && matched && better) begin
      hit <= 1'b1;
    end
    if (rd_vld && matched && better) begin
      best       <= rd_data;
      best_index <= rd_index;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_out) begin
      found         <= hit;
      match_index   <= hit ? lpm_pkg::IDX_W'(CW'(best_index)) : '0;
      match_gateway <= hit ? best.gateway : '0;
      match_port    <= hit ? best.port : '0;
    end
  end

endmodule

// ===== design/longest_prefix_match_lookup.sv =====
// Top level of the longest-prefix-match route lookup.
// A write beat is written to the table on accept. A lookup scans the entries in
// range, one table read per cycle on the single memory read port, then compares
// and loads the result once the output register is free; an empty range skips the scan.
// The next beat is accepted once the result is in the output register.
// Reset clears control, first_entry to 0 and last_entry to -1; table contents
// are undefined until written.
module longest_prefix_match_lookup #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  // input beats
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // entry_index, route_prefix, route_mask, route_next_hop, route_port, dest_addr
  input  logic [lpm_pkg::IN_DATA_W-1:0]     s_tdata,
  // op
  input  logic                              s_tuser,
  // result beats
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // match_index, match_next_hop, match_port
  output logic [lpm_pkg::OUT_DATA_W-1:0]    m_tdata,
  // found
  output logic                              m_tuser,
  // configuration
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [lpm_pkg::LAST_W-1:0]        cfg_data
);

  lpm_pkg::lpm_cmd_t     cmd;
  lpm_pkg::lpm_sts_t     sts;
  lpm_pkg::route_entry_t wr_entry;

  logic [lpm_pkg::IDX_W-1:0]  match_index;
  logic [lpm_pkg::ADDR_W-1:0] match_gateway;
  logic [lpm_pkg::PORT_W-1:0] match_port;

  // Unpack the write entry
  assign wr_entry.prefix  = s_tdata[41:10];
  assign wr_entry.mask    = s_tdata[73:42];
  assign wr_entry.gateway = s_tdata[105:74];
  assign wr_entry.port    = s_tdata[113:106];

  lpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .sts      (sts),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  lpm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .entry_index   (s_tdata[9:0]),
    .wr_entry      (wr_entry),
    .dest_addr     (s_tdata[145:114]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .found         (m_tuser),
    .match_index   (match_index),
    .match_gateway (match_gateway),
    .match_port    (match_port)
  );

  // Pack the result beat
  assign m_tdata = {6'b0, match_port, match_gateway, match_index};

endmodule
